[design/crcpf_pkg.sv]
// Shared types, constants and CRC helper for the CRC-32 packet framer.
`default_nettype none
package crcpf_pkg;

	// Input op codes carried in tuser
	localparam logic OP_HDR  = 1'b0;
	localparam logic OP_DATA = 1'b1;

	// Configuration register indexes (paddr[2])
	localparam logic REG_CAP = 1'b0;

	localparam logic [15:0] CAP_RESET = 16'd528;
	localparam int MAX_PAYLOAD   = 512;
	localparam int HDR_BASE      = 11;   // header bytes with a one-byte length
	localparam int SHORT_LEN_MAX = 127;
	localparam int HDR_LAST      = 10;   // last header step with a one-byte length
	localparam int CRC_BYTES     = 4;
	localparam int FIFO_DEPTH    = 4;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	typedef enum logic [1:0] {
		CMD_HDR  = 2'd0,
		CMD_DATA = 2'd1,
		CMD_ERR  = 2'd2
	} cmd_kind_t;

	// One command from the front to the back
	typedef struct packed {
		cmd_kind_t   kind;
		logic [1:0]  pkt_kind;
		logic        truncated;
		logic [4:0]  window_size;
		logic [9:0]  payload_len;
		logic [7:0]  seq_no;
		logic [31:0] time_stamp;
		logic [7:0]  data_byte;
		logic        last;         // data byte closes the payload
		logic [9:0]  frame_bytes;
	} cmd_t;

	// Reflected CRC-32 update with one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'b0, b};
		for (int i = 0; i < 8; i++) begin
			x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
		end
		return x;
	endfunction

endpackage
`default_nettype wire

[design/crc32_packet_framer_unit.sv]
// Top level of the CRC-32 packet framer: configuration register, front, queue and back.
//
// Usage:
//  - s_axis carries input items. tuser = op (0 header, 1 payload byte).
//    A header item starts a frame; payload items follow, one byte each.
//  - m_axis carries frame bytes, one per item. tlast marks the last byte of a
//    frame (or an error result), tuser flags an oversize frame, and
//    tdata[17:8] gives the frame length alongside tlast.
//  - APB register 0 (address 0): frame_capacity, 16 bits, reset 528.
// Timing: an accepted item goes into the command queue, then the back loads its
//  first byte into the output register. A header expands to 11 or 12 bytes, a
//  payload byte to one, the last payload byte to five (byte plus CRC). Payload
//  streams at one item per cycle while the queue has room; the four-entry command
//  queue absorbs header bursts, and s_axis_tready drops only while that queue is full.
// A stalled receiver holds the output register; the queue fills behind it and
//  then backpressures the input. Reset empties the queue, clears the frame
//  state and restores the capacity register; no clearing pass is needed.
`default_nettype none
module crc32_packet_framer_unit #(
	parameter int FIFO_DEPTH = crcpf_pkg::FIFO_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	// Input stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: pkt_kind[1:0], truncated[2], window_size[7:3], payload_len[17:8],
	//        seq_no[25:18], time_stamp[57:26], data_byte[65:58], zero fill
	input  wire  [71:0] s_axis_tdata,
	input  wire         s_axis_tuser,   // op
	// Output stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// tdata: out_byte[7:0], frame_bytes[17:8], zero fill
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast,   // frame_end
	output logic        m_axis_tuser,   // status
	// Configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [15:0] cap_q;
	logic        in_accept, q_full, q_empty, q_push, q_pop;
	crcpf_pkg::cmd_t q_in, q_head;
	logic [7:0]  out_byte;
	logic [9:0]  frame_bytes;

	// Register file: one 16-bit capacity register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == crcpf_pkg::REG_CAP) ? {16'b0, cap_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= crcpf_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == crcpf_pkg::REG_CAP) begin
			cap_q <= pwdata[15:0];
		end
	end

	// Take a new item whenever the queue has room
	assign s_axis_tready = !q_full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	crcpf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_accept),
		.op       (s_axis_tuser),
		.fields   (s_axis_tdata[65:0]),
		.capacity (cap_q),
		.push     (q_push),
		.cmd      (q_in)
	);

	crcpf_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	crcpf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.empty       (q_empty),
		.pop         (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (out_byte),
		.frame_end   (m_axis_tlast),
		.status      (m_axis_tuser),
		.frame_bytes (frame_bytes)
	);

	assign m_axis_tdata = {6'b0, frame_bytes, out_byte};

endmodule
`default_nettype wire

[design/crcpf_fifo.sv]
// Command queue between the framer front and back.
`default_nettype none
module crcpf_fifo #(
	parameter int DEPTH = crcpf_pkg::FIFO_DEPTH
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  crcpf_pkg::cmd_t   push_cmd,
	output logic              full,
	input  wire               pop,
	output crcpf_pkg::cmd_t   head,
	output logic              empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	crcpf_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |-> !push)
		else $error("push into a full queue");
`endif

endmodule
`default_nettype wire

[design/crcpf_front.sv]
// Front: accept items, track frame state, decide which command each item becomes.
`default_nettype none
module crcpf_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               accept,
	input  wire               op,
	input  wire  [65:0]       fields,
	input  wire  [15:0]       capacity,
	output logic              push,
	output crcpf_pkg::cmd_t   cmd
);
	logic [9:0] bytes_left_q, frame_len_q;
	logic       dropping_q;

	logic [9:0] bytes_left_d, frame_len_d;
	logic       dropping_d;

	logic [1:0]  pkt_kind;
	logic        truncated;
	logic [4:0]  window_size;
	logic [9:0]  payload_len;
	logic [7:0]  seq_no;
	logic [31:0] time_stamp;
	logic [7:0]  data_byte;

	logic        lng, too_big;
	logic [10:0] size;
	logic [9:0]  fb, left_dec;

	assign pkt_kind    = fields[1:0];
	assign truncated   = fields[2];
	assign window_size = fields[7:3];
	assign payload_len = fields[17:8];
	assign seq_no      = fields[25:18];
	assign time_stamp  = fields[57:26];
	assign data_byte   = fields[65:58];

	assign lng  = (payload_len > 10'(crcpf_pkg::SHORT_LEN_MAX));
	assign size = 11'(crcpf_pkg::HDR_BASE) + {10'b0, lng} + {1'b0, payload_len}
		+ ((payload_len != '0) ? 11'(crcpf_pkg::CRC_BYTES) : 11'd0);
	assign fb   = size[10] ? 10'h3FF : size[9:0];
	assign too_big = ({6'b0, payload_len} > 16'(crcpf_pkg::MAX_PAYLOAD))
		|| ({5'b0, size} > capacity);
	assign left_dec = bytes_left_q - 1'b1;

	always_comb begin
		bytes_left_d = bytes_left_q;
		frame_len_d  = frame_len_q;
		dropping_d   = dropping_q;
		push         = 1'b0;
		cmd          = '0;
		cmd.pkt_kind    = pkt_kind;
		cmd.truncated   = truncated;
		cmd.window_size = window_size;
		cmd.payload_len = payload_len;
		cmd.seq_no      = seq_no;
		cmd.time_stamp  = time_stamp;
		cmd.data_byte   = data_byte;
		if (accept) begin
			if (op == crcpf_pkg::OP_HDR) begin
				// a header always restarts the frame, even mid-payload
				bytes_left_d    = payload_len;
				frame_len_d     = fb;
				dropping_d      = too_big && (payload_len != '0);
				push            = 1'b1;
				cmd.kind        = too_big ? crcpf_pkg::CMD_ERR : crcpf_pkg::CMD_HDR;
				cmd.frame_bytes = fb;
			end else if (bytes_left_q == '0) begin
				dropping_d = 1'b0;   // stray byte: drop
			end else begin
				bytes_left_d = left_dec;
				if (dropping_q) begin
					if (left_dec == '0) begin
						dropping_d = 1'b0;
					end
				end else begin
					push            = 1'b1;
					cmd.kind        = crcpf_pkg::CMD_DATA;
					cmd.last        = (left_dec == '0);
					cmd.frame_bytes = frame_len_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			frame_len_q  <= '0;
			dropping_q   <= 1'b0;
		end else begin
			bytes_left_q <= bytes_left_d;
			frame_len_q  <= frame_len_d;
			dropping_q   <= dropping_d;
		end
	end

endmodule
`default_nettype wire

[design/crcpf_back.sv]
// Back: expand queued commands into frame bytes and hold them in the output register.
`default_nettype none
module crcpf_back (
	input  wire               clk,
	input  wire               arst_n,
	input  crcpf_pkg::cmd_t   head,
	input  wire               empty,
	output logic              pop,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [7:0]        out_byte,
	output logic              frame_end,
	output logic              status,
	output logic [9:0]        frame_bytes
);
	logic [3:0]  step_q;
	logic [31:0] crc_q;
	logic        valid_q, end_q, status_q;
	logic [7:0]  byte_q;
	logic [9:0]  fb_q;

	logic        load, last_step, lng;
	logic [3:0]  q;
	logic [7:0]  byte_d;
	logic        end_d, status_d;
	logic [31:0] crc_d, crc_out, crc_fin;

	assign load    = !empty && (!valid_q || out_ready);
	assign pop     = load && last_step;
	assign lng     = (head.payload_len > 10'(crcpf_pkg::SHORT_LEN_MAX));
	assign q       = step_q - {3'b0, lng};
	assign crc_out = head.truncated ? 32'h0 : ~crc_q;
	assign crc_fin = ~crc_q;

	always_comb begin
		byte_d    = '0;
		end_d     = 1'b0;
		status_d  = 1'b0;
		crc_d     = crc_q;
		last_step = 1'b1;
		unique case (head.kind)
			crcpf_pkg::CMD_HDR: begin
				last_step = (step_q == 4'(crcpf_pkg::HDR_LAST) + {3'b0, lng});
				end_d     = last_step && (head.payload_len == '0);
				if (step_q == 4'd0) begin
					byte_d = {head.pkt_kind, head.truncated, head.window_size};
					crc_d  = crcpf_pkg::crc_byte(crcpf_pkg::CRC_INIT, byte_d);
				end else if (step_q == 4'd1) begin
					byte_d = lng ? {6'b100000, head.payload_len[9:8]}
						: head.payload_len[7:0];
					crc_d  = crcpf_pkg::crc_byte(crc_q, byte_d);
				end else if (lng && step_q == 4'd2) begin
					byte_d = head.payload_len[7:0];
					crc_d  = crcpf_pkg::crc_byte(crc_q, byte_d);
				end else begin
					unique case (q)
						4'd2:    byte_d = head.seq_no;
						4'd3:    byte_d = head.time_stamp[7:0];
						4'd4:    byte_d = head.time_stamp[15:8];
						4'd5:    byte_d = head.time_stamp[23:16];
						4'd6:    byte_d = head.time_stamp[31:24];
						4'd7:    byte_d = crc_out[31:24];
						4'd8:    byte_d = crc_out[23:16];
						4'd9:    byte_d = crc_out[15:8];
						4'd10:   byte_d = crc_out[7:0];
						default: byte_d = '0;
					endcase
					if (q <= 4'd6) begin
						crc_d = crcpf_pkg::crc_byte(crc_q, byte_d);
					end
				end
				// payload CRC starts fresh after the header
				if (last_step) begin
					crc_d = crcpf_pkg::CRC_INIT;
				end
			end
			crcpf_pkg::CMD_DATA: begin
				unique case (step_q)
					4'd0: begin
						byte_d    = head.data_byte;
						crc_d     = crcpf_pkg::crc_byte(crc_q, head.data_byte);
						last_step = !head.last;
					end
					4'd1: begin byte_d = crc_fin[31:24]; last_step = 1'b0; end
					4'd2: begin byte_d = crc_fin[23:16]; last_step = 1'b0; end
					4'd3: begin byte_d = crc_fin[15:8];  last_step = 1'b0; end
					default: begin
						byte_d = crc_fin[7:0];
						end_d  = 1'b1;
						crc_d  = crcpf_pkg::CRC_INIT;
					end
				endcase
			end
			default: begin
				end_d    = 1'b1;
				status_d = 1'b1;
				crc_d    = crcpf_pkg::CRC_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= '0;
			crc_q   <= crcpf_pkg::CRC_INIT;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				step_q  <= last_step ? 4'd0 : step_q + 1'b1;
				crc_q   <= crc_d;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= byte_d;
			end_q    <= end_d;
			status_q <= status_d;
			fb_q     <= end_d ? head.frame_bytes : 10'd0;
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign frame_end   = end_q;
	assign status      = status_q;
	assign frame_bytes = fb_q;

`ifndef NO_ASSERTIONS
	a_err_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && status_q) |-> (end_q && byte_q == 8'd0))
		else $error("error result not a closing zero byte");
	a_len_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !end_q) |-> (fb_q == 10'd0))
		else $error("frame length shown before frame end");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < 4'd12)
		else $error("step counter out of range");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the CRC-32 packet framer: directed and random frames.
`default_nettype none
module tb_top;

	// Frame length field saturates here
	localparam int FB_MAX = 1023;
	// Receiver hold-off that forces the command queue to fill and stall the input
	localparam int HOLD_CYCLES = 300;
	// Cycles to let queued no-result items (dropped or stray bytes) drain
	localparam int DRAIN_CYCLES = 24;
	localparam int END_CYCLES = 40;
	// Cycles without any accepted item before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;

	// Predicts the byte stream of the framer and checks each output item
	class frame_scoreboard;
		typedef struct {
			logic [7:0] octet;
			logic       frame_end;
			logic       status;
			logic [9:0] frame_bytes;
		} frame_out_t;

		frame_out_t  expected_bytes[$];
		logic [15:0] capacity = crcpf_pkg::CAP_RESET;
		logic [31:0] payload_crc = crcpf_pkg::CRC_INIT;
		logic [9:0]  bytes_left = '0;
		logic [9:0]  frame_len = '0;
		logic        dropping = 1'b0;
		int unsigned errors = 0;

		// Reflected CRC-32, one data bit per step, low bit first
		static function logic [31:0] crc_shift(logic [31:0] c, logic [7:0] b);
			logic [31:0] r;
			r = c;
			for (int i = 0; i < 8; i++) begin
				if (r[0] ^ b[i])
					r = (r >> 1) ^ crcpf_pkg::CRC_POLY;
				else
					r = r >> 1;
			end
			return r;
		endfunction

		function void push(logic [7:0] o, logic e, logic s, logic [9:0] fb);
			frame_out_t x;
			x.octet = o;
			x.frame_end = e;
			x.status = s;
			x.frame_bytes = fb;
			expected_bytes.push_back(x);
		endfunction

		function void note_item(logic op, logic [71:0] d);
			logic [1:0]  kind;
			logic        tr;
			logic [4:0]  win;
			logic [9:0]  len;
			logic [7:0]  seq;
			logic [31:0] ts;
			logic [7:0]  octet;
			logic [7:0]  hdr[$];
			logic [31:0] c;
			logic [9:0]  fb;
			logic        last_one;
			int          frame_size;
			{ts, seq, len, win, tr, kind} = d[57:0];
			octet = d[65:58];
			if (op == crcpf_pkg::OP_HDR) begin
				frame_size = crcpf_pkg::HDR_BASE + int'(len)
					+ (len > crcpf_pkg::SHORT_LEN_MAX ? 1 : 0)
					+ (len != 0 ? crcpf_pkg::CRC_BYTES : 0);
				fb = frame_size > FB_MAX ? 10'(FB_MAX) : 10'(frame_size);
				// A new header always abandons whatever frame was open
				payload_crc = crcpf_pkg::CRC_INIT;
				frame_len = fb;
				bytes_left = len;
				if (len > crcpf_pkg::MAX_PAYLOAD || frame_size > capacity) begin
					dropping = len != 0;
					push(8'h00, 1'b1, 1'b1, fb);
					return;
				end
				dropping = 1'b0;
				hdr.push_back({kind, tr, win});
				if (len > crcpf_pkg::SHORT_LEN_MAX) begin
					hdr.push_back({6'b100000, len[9:8]});
					hdr.push_back(len[7:0]);
				end else
					hdr.push_back(len[7:0]);
				hdr.push_back(seq);
				for (int i = 0; i < 4; i++)
					hdr.push_back(ts[8*i +: 8]);
				c = crcpf_pkg::CRC_INIT;
				foreach (hdr[i])
					c = crc_shift(c, hdr[i]);
				c = tr ? 32'h0 : ~c;
				for (int i = 3; i >= 0; i--)
					hdr.push_back(c[8*i +: 8]);
				foreach (hdr[i]) begin
					last_one = (i == hdr.size() - 1) && (len == 0);
					push(hdr[i], last_one, 1'b0, last_one ? fb : 10'd0);
				end
			end else begin
				if (bytes_left == 0) begin
					dropping = 1'b0;
					return;
				end
				bytes_left--;
				if (dropping) begin
					if (bytes_left == 0)
						dropping = 1'b0;
					return;
				end
				payload_crc = crc_shift(payload_crc, octet);
				push(octet, 1'b0, 1'b0, 10'd0);
				if (bytes_left == 0) begin
					c = ~payload_crc;
					for (int i = 3; i >= 0; i--)
						push(c[8*i +: 8], i == 0, 1'b0, i == 0 ? frame_len : 10'd0);
					payload_crc = crcpf_pkg::CRC_INIT;
				end
			end
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, actual %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [23:0] d, logic fend, logic st);
			frame_out_t x;
			if (expected_bytes.size() == 0) begin
				$error("out_byte %0h arrived with nothing expected", d[7:0]);
				errors++;
				return;
			end
			x = expected_bytes.pop_front();
			compare_field("out_byte", 32'(x.octet), 32'(d[7:0]));
			compare_field("frame_end", 32'(x.frame_end), 32'(fend));
			compare_field("status", 32'(x.status), 32'(st));
			compare_field("frame_bytes", 32'(x.frame_bytes), 32'(d[17:8]));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	// tdata: pkt_kind, truncated, window_size, payload_len, seq_no, time_stamp,
	//        data_byte, zero fill
	logic [71:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;   // op
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// tdata: out_byte, frame_bytes, zero fill
	wire  [23:0] m_axis_tdata;
	wire         m_axis_tlast;          // frame_end
	wire         m_axis_tuser;          // status
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;

	frame_scoreboard sb = new();

	// Idling control: calm stretches on each side, and none at all near the end
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	bit          calm_end = 1'b0;
	int unsigned hold_reqs = 0;
	int unsigned hold_seen = 0;
	int unsigned rx_gap = 0;
	int unsigned stuck_cycles = 0;

	crc32_packet_framer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Sample both handshakes at the edge: check the result first, then note the
	// input item, so the expectation order never depends on process order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_item(s_axis_tuser, s_axis_tdata);
		end
	end

	// Receiver: random stall bursts, calm stretches, and one long hold-off on request
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			rx_gap = HOLD_CYCLES;
		end
		if ($urandom_range(0, 63) == 0)
			rx_calm = !rx_calm;
		if (rx_gap != 0) begin
			m_axis_tready <= 1'b0;
			rx_gap--;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm_end && !rx_calm && $urandom_range(0, 7) == 0)
				rx_gap = $urandom_range(1, 19);
		end
	end

	// Watchdog: end the run when nothing moves on either stream for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	function automatic logic [71:0] header_word(logic [1:0] kind, logic tr, logic [4:0] win,
		logic [9:0] len, logic [7:0] seq, logic [31:0] ts);
		logic [7:0] junk;
		// The data byte field is unused on a header; fill it anyway
		junk = 8'($urandom);
		return {6'b0, junk, ts, seq, len, win, tr, kind};
	endfunction

	function automatic logic [71:0] payload_word(logic [7:0] b);
		logic [71:0] w;
		// Randomize the header fields too; the block must ignore them here
		w = {8'($urandom), 32'($urandom), 32'($urandom)};
		w[71:66] = '0;
		w[65:58] = b;
		return w;
	endfunction

	// Offer one item, with an optional idle burst first, and hold until accepted
	task automatic send_item(input logic op, input logic [71:0] word);
		if (!calm_end && !tx_calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Header with random fields and the given length, then some payload bytes
	task automatic send_frame(input int len, input int sent_bytes);
		send_item(crcpf_pkg::OP_HDR, header_word(2'($urandom), $urandom_range(0, 3) == 0,
			5'($urandom), 10'(len), 8'($urandom), $urandom));
		repeat (sent_bytes)
			send_item(crcpf_pkg::OP_DATA, payload_word(8'($urandom)));
	endtask

	// Drop tvalid, let the last accepted item be noted, wait out every expected
	// byte, then let queued silent items drain
	task automatic wait_drained(input int settle);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Write the capacity register while idle, then read it back
	task automatic write_capacity(input logic [15:0] value);
		wait_drained(DRAIN_CYCLES);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {crcpf_pkg::REG_CAP, 2'b00};
		pwdata <= {16'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.capacity = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {16'h0, value}) begin
			$error("frame_capacity: expected %0h, actual %0h", {16'h0, value}, prdata);
			sb.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly well-formed frames; some oversize, cut-short and stray traffic
	task automatic run_random(input int target);
		int sent;
		int pick;
		int len;
		int n;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 84) begin
				if (pick < 52)
					len = $urandom_range(0, 16);
				else if (pick < 76)
					len = $urandom_range(17, 70);
				else
					len = $urandom_range(120, 136);
				send_frame(len, len);
				sent += 1 + len;
			end else if (pick < 90) begin
				// Oversize length: a few dropped bytes, then the next header abandons it
				send_frame($urandom_range(crcpf_pkg::MAX_PAYLOAD + 1, FB_MAX),
					$urandom_range(0, 4));
				sent += 1;
			end else if (pick < 96) begin
				len = $urandom_range(2, 30);
				n = $urandom_range(0, len - 1);
				send_frame(len, n);
				sent += 1 + n;
			end else begin
				repeat ($urandom_range(1, 3))
					send_item(crcpf_pkg::OP_DATA, payload_word(8'($urandom)));
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset capacity
		// Empty payload, all fields low, then all fields high with truncated set
		send_item(crcpf_pkg::OP_HDR, header_word(2'd0, 1'b0, 5'd0, 10'd0, 8'h00, 32'h0));
		send_item(crcpf_pkg::OP_HDR,
			header_word(2'd3, 1'b1, 5'd31, 10'd0, 8'hFF, 32'hFFFFFFFF));
		// Stray byte with no open frame
		send_item(crcpf_pkg::OP_DATA, payload_word(8'h5A));
		send_item(crcpf_pkg::OP_HDR,
			header_word(2'd1, 1'b0, 5'd10, 10'd2, 8'h01, 32'h12345678));
		send_item(crcpf_pkg::OP_DATA, payload_word(8'h00));
		send_item(crcpf_pkg::OP_DATA, payload_word(8'hFF));
		send_item(crcpf_pkg::OP_DATA, payload_word(8'hA5));
		// Header arriving mid-frame abandons the open one
		send_item(crcpf_pkg::OP_HDR,
			header_word(2'd2, 1'b0, 5'd21, 10'd3, 8'h7F, 32'h80000001));
		send_item(crcpf_pkg::OP_DATA, payload_word(8'h80));
		send_item(crcpf_pkg::OP_HDR,
			header_word(2'd1, 1'b1, 5'd5, 10'd1, 8'h80, 32'h00FF00FF));
		send_item(crcpf_pkg::OP_DATA, payload_word(8'h01));
		// Longest one-byte length, then shortest two-byte length
		send_item(crcpf_pkg::OP_HDR,
			header_word(2'd1, 1'b0, 5'd3, 10'd127, 8'h55, 32'hA5A5A5A5));
		send_item(crcpf_pkg::OP_HDR,
			header_word(2'd2, 1'b0, 5'd12, 10'd128, 8'hAA, 32'h5A5A5A5A));
		// Oversize lengths (the first with a saturated frame length), payload dropped
		send_item(crcpf_pkg::OP_HDR,
			header_word(2'd0, 1'b0, 5'd0, 10'd1023, 8'h10, 32'h0));
		send_item(crcpf_pkg::OP_DATA, payload_word(8'h11));
		send_item(crcpf_pkg::OP_DATA, payload_word(8'h22));
		send_item(crcpf_pkg::OP_HDR,
			header_word(2'd3, 1'b1, 5'd31, 10'd513, 8'h20, 32'h1));
		send_item(crcpf_pkg::OP_DATA, payload_word(8'h33));

		// Hold the receiver off so the queue fills and the input stalls
		hold_reqs++;
		run_random(70);

		write_capacity(16'hFFFF);
		run_random(35);

		// Zero capacity rejects every frame, empty ones included
		write_capacity(16'h0000);
		run_random(10);

		// Only an empty frame fits
		write_capacity(16'(crcpf_pkg::HDR_BASE));
		run_random(10);

		write_capacity(16'($urandom_range(12, 80)));
		run_random(35);

		// Last part: reset capacity again, no idling on either side
		write_capacity(crcpf_pkg::CAP_RESET);
		calm_end = 1'b1;
		run_random(40);

		wait_drained(END_CYCLES);
		if (sb.errors == 0 && sb.expected_bytes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
design/crcpf_pkg.sv
design/crcpf_fifo.sv
design/crcpf_front.sv
design/crcpf_back.sv
design/crc32_packet_framer_unit.sv
tb/tb_top.sv
